>>> rtl/iprw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iprw_pkg
// Shared types, constants and checksum arithmetic for the IPv4 address
// rewrite and incremental checksum repair unit.
// ----------------------------------------------------------------------------
package iprw_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [15:0] CSUM_ONES  = 16'hffff;
	localparam logic [15:0] CSUM_ZERO  = 16'h0000;

	// Classified item passed from the front to the back through the queue
	typedef struct packed {
		logic        is_udp;
		logic        changed;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] nsrc;
		logic [31:0] ndst;
		logic [15:0] ipc;
		logic [15:0] l4c;
	} item_t;

	typedef struct packed {
		logic [31:0] nsrc;
		logic [31:0] ndst;
		logic [15:0] ipc;
		logic [15:0] l4c;
		logic        changed;
	} res_t;

	// Incremental ones'-complement update: ~(~chk + ~old + new), two folds
	function automatic logic [15:0] csum_update(input logic [15:0] chk,
		input logic [31:0] old_w, input logic [31:0] new_w);
		logic [31:0] inv_old;
		logic [15:0] inv_chk;
		logic [18:0] s;
		logic [16:0] f1;
		logic [16:0] f2;
		inv_old = ~old_w;
		// invert at 16 bits before widening
		inv_chk = ~chk;
		s  = 19'(CSUM_ONES) + 19'(inv_chk) + 19'(inv_old[31:16]) + 19'(inv_old[15:0])
			+ 19'(new_w[31:16]) + 19'(new_w[15:0]);
		f1 = 17'(s[15:0]) + 17'(s[18:16]);
		f2 = 17'(f1[15:0]) + 17'(f1[16]);
		return ~f2[15:0];
	endfunction

	// UDP never stores the no-checksum mark
	function automatic logic [15:0] udp_fix(input logic is_udp, input logic [15:0] c);
		return (is_udp && (c == CSUM_ZERO)) ? CSUM_ONES : c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/iprw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iprw_front
// Holds the force mask, applies it to the addresses and classifies each
// accepted item by protocol before it enters the queue.
// ----------------------------------------------------------------------------
module iprw_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire logic [31:0]       cfg_data,
	input  wire logic              push,
	input  wire logic [7:0]        ip_protocol,
	input  wire logic [31:0]       src_addr,
	input  wire logic [31:0]       dst_addr,
	input  wire logic [15:0]       ip_checksum,
	input  wire logic [15:0]       l4_checksum,
	output      logic              wr_en,
	output      iprw_pkg::item_t   wr_item
);
	import iprw_pkg::*;

	logic [31:0] force_mask_q;
	logic        is_tcp;
	logic        is_udp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			force_mask_q <= cfg_data;
		end
	end

	assign is_tcp = (ip_protocol == PROTO_TCP);
	// zero UDP checksum means none: leave it alone
	assign is_udp = (ip_protocol == PROTO_UDP) && (l4_checksum != CSUM_ZERO);

	assign wr_en = push;

	always_comb begin
		wr_item.is_udp  = is_udp;
		wr_item.changed = is_tcp || is_udp;
		wr_item.src     = src_addr;
		wr_item.dst     = dst_addr;
		wr_item.nsrc    = src_addr | force_mask_q;
		wr_item.ndst    = dst_addr & ~force_mask_q;
		wr_item.ipc     = ip_checksum;
		wr_item.l4c     = l4_checksum;
	end

endmodule
`default_nettype wire

>>> rtl/iprw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iprw_queue
// Short register queue between the front and the back, so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module iprw_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire iprw_pkg::item_t   wr_item,
	output      logic              full,
	input  wire logic              rd_en,
	output      iprw_pkg::item_t   rd_item,
	output      logic              rd_vld
);
	import iprw_pkg::*;

	item_t           mem_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  count_q;
	logic            do_wr;
	logic            do_rd;

	assign full   = (count_q == QCW'(QDEPTH));
	assign rd_vld = (count_q != '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && rd_vld;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("queue count above depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on write");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");

endmodule
`default_nettype wire

>>> rtl/iprw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iprw_back
// Two-stage checksum repair: the source update in the first stage, the
// destination update in the second, whose register holds the result.
// ----------------------------------------------------------------------------
module iprw_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire iprw_pkg::item_t   in_item,
	output      logic              in_ready,
	output      logic              out_vld,
	output      iprw_pkg::res_t    out_res,
	input  wire logic              out_pop
);
	import iprw_pkg::*;

	logic        vld_s1;
	logic        vld_s2;
	logic        ready_s1;
	logic        ready_s2;
	logic        is_udp_s1;
	logic        changed_s1;
	logic [31:0] dst_s1;
	logic [31:0] nsrc_s1;
	logic [31:0] ndst_s1;
	logic [15:0] ipc_s1;
	logic [15:0] l4c_s1;
	logic [15:0] l4c_orig_s1;
	res_t        res_s2;
	logic [15:0] l4c_upd;

	assign ready_s2 = !vld_s2 || out_pop;
	assign ready_s1 = !vld_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				vld_s1 <= in_vld;
			end
			if (ready_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// source word replacement
	always_ff @(posedge clk) begin
		if (ready_s1 && in_vld) begin
			is_udp_s1   <= in_item.is_udp;
			changed_s1  <= in_item.changed;
			dst_s1      <= in_item.dst;
			nsrc_s1     <= in_item.nsrc;
			ndst_s1     <= in_item.ndst;
			ipc_s1      <= csum_update(in_item.ipc, in_item.src, in_item.nsrc);
			l4c_s1      <= udp_fix(in_item.is_udp,
				csum_update(in_item.l4c, in_item.src, in_item.nsrc));
			l4c_orig_s1 <= in_item.l4c;
		end
	end

	assign l4c_upd = udp_fix(is_udp_s1, csum_update(l4c_s1, dst_s1, ndst_s1));

	// destination word replacement
	always_ff @(posedge clk) begin
		if (ready_s2 && vld_s1) begin
			res_s2.nsrc    <= nsrc_s1;
			res_s2.ndst    <= ndst_s1;
			res_s2.ipc     <= csum_update(ipc_s1, dst_s1, ndst_s1);
			res_s2.l4c     <= changed_s1 ? l4c_upd : l4c_orig_s1;
			res_s2.changed <= changed_s1;
		end
	end

	assign out_vld = vld_s2;
	assign out_res = res_s2;

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !out_pop) |=> (vld_s2 && $stable(res_s2)))
		else $error("result stage changed while stalled");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && ready_s2) |=> vld_s2)
		else $error("first stage item lost");

	a_no_udp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && is_udp_s1) |-> (l4c_s1 != CSUM_ZERO))
		else $error("UDP checksum turned into no-checksum mark");

endmodule
`default_nettype wire

>>> rtl/ip_address_rewrite_csum_fix_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ip_address_rewrite_csum_fix_unit
// IPv4 address rewrite with incremental header and layer-4 checksum repair.
// ----------------------------------------------------------------------------
// Takes one parsed header item per cycle unless full, returns one result per
// item, in order. The force mask is set in the source address and cleared in
// the destination address, and both checksums are repaired incrementally; TCP
// checksums are always repaired, UDP only when nonzero. Sustained rate is one
// item per cycle while results are popped: each checksum stage has a six-term
// adder with fold per checksum, the first for the source word, the second for
// the destination word. Items pass the queue and the stage registers; a
// four-entry queue between the front and the checksum stages lets input
// continue while results wait. The force mask is written through cfg_valid,
// which is always ready, and must only change while the unit is idle.
module ip_address_rewrite_csum_fix_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        push,
	output      logic        full,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [31:0] src_addr,
	input  wire logic [31:0] dst_addr,
	input  wire logic [15:0] ip_checksum,
	input  wire logic [15:0] l4_checksum,
	output      logic        empty,
	input  wire logic        pop,
	output      logic [31:0] new_src_addr,
	output      logic [31:0] new_dst_addr,
	output      logic [15:0] new_ip_checksum,
	output      logic [15:0] new_l4_checksum,
	output      logic        l4_changed
);
	import iprw_pkg::*;

	logic  wr_en;
	item_t wr_item;
	logic  q_full;
	logic  q_vld;
	item_t q_item;
	logic  back_ready;
	logic  out_vld;
	res_t  out_res;

	iprw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.push        (push),
		.ip_protocol (ip_protocol),
		.src_addr    (src_addr),
		.dst_addr    (dst_addr),
		.ip_checksum (ip_checksum),
		.l4_checksum (l4_checksum),
		.wr_en       (wr_en),
		.wr_item     (wr_item)
	);

	iprw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_item (wr_item),
		.full    (q_full),
		.rd_en   (back_ready),
		.rd_item (q_item),
		.rd_vld  (q_vld)
	);

	iprw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (q_vld),
		.in_item  (q_item),
		.in_ready (back_ready),
		.out_vld  (out_vld),
		.out_res  (out_res),
		.out_pop  (pop)
	);

	assign full            = q_full;
	assign empty           = !out_vld;
	assign new_src_addr    = out_res.nsrc;
	assign new_dst_addr    = out_res.ndst;
	assign new_ip_checksum = out_res.ipc;
	assign new_l4_checksum = out_res.l4c;
	assign l4_changed      = out_res.changed;

endmodule
`default_nettype wire

>>> tb/ip_address_rewrite_csum_fix_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_rewrite_csum_fix_unit_test
// Drives parsed IPv4 header items into the address rewrite unit and checks
// every result against an in-bench model of the mask rewrite and of the
// incremental header and layer-4 checksum repair. The run goes through
// several force masks, the extremes among them, and uses random gaps on
// both sides, one quiet stretch and one long receiver stall.
// ----------------------------------------------------------------------------
module ip_address_rewrite_csum_fix_unit_test;

	import iprw_pkg::*;

	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned COOLDOWN    = 8;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] ipc;
		logic [15:0] l4c;
	} header_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [31:0] cfg_data  = '0;
	logic        push      = 1'b0;
	logic        pop       = 1'b0;
	header_t     cur_hdr   = '0;

	wire logic        cfg_ready;
	wire logic        full;
	wire logic        empty;
	wire logic [31:0] new_src_addr;
	wire logic [31:0] new_dst_addr;
	wire logic [15:0] new_ip_checksum;
	wire logic [15:0] new_l4_checksum;
	wire logic        l4_changed;

	header_t     header_pending[$];
	res_t        rewrite_expected[$];
	logic [31:0] mask_shadow = '0;
	logic        quiet       = 1'b0;
	logic        hold_go     = 1'b0;
	logic        hold_done   = 1'b0;
	int unsigned hold_left   = 0;
	int unsigned err_cnt     = 0;

	ip_address_rewrite_csum_fix_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.push            (push),
		.full            (full),
		.ip_protocol     (cur_hdr.proto),
		.src_addr        (cur_hdr.src),
		.dst_addr        (cur_hdr.dst),
		.ip_checksum     (cur_hdr.ipc),
		.l4_checksum     (cur_hdr.l4c),
		.empty           (empty),
		.pop             (pop),
		.new_src_addr    (new_src_addr),
		.new_dst_addr    (new_dst_addr),
		.new_ip_checksum (new_ip_checksum),
		.new_l4_checksum (new_l4_checksum),
		.l4_changed      (l4_changed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Replace a 32-bit word in a ones'-complement checksum: ~(~chk + ~old + new)
	function automatic logic [15:0] csum_patch(input logic [15:0] chk,
		input logic [31:0] old_w, input logic [31:0] new_w);
		logic [31:0] inv_old;
		logic [31:0] s;
		inv_old = ~old_w;
		s = 32'h0000_ffff + {16'h0, ~chk} + {16'h0, inv_old[31:16]}
			+ {16'h0, inv_old[15:0]} + {16'h0, new_w[31:16]} + {16'h0, new_w[15:0]};
		while (s > 32'h0000_ffff)
			s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
		return ~s[15:0];
	endfunction

	function automatic res_t predict_rewrite(input header_t h, input logic [31:0] mask);
		res_t r;
		logic is_tcp;
		logic is_udp;
		is_tcp    = (h.proto == PROTO_TCP);
		is_udp    = (h.proto == PROTO_UDP) && (h.l4c != CSUM_ZERO);
		r.nsrc    = h.src | mask;
		r.ndst    = h.dst & ~mask;
		r.changed = is_tcp || is_udp;
		r.ipc     = csum_patch(csum_patch(h.ipc, h.src, r.nsrc), h.dst, r.ndst);
		r.l4c     = h.l4c;
		if (r.changed) begin
			// UDP must never end up with the no-checksum mark
			r.l4c = csum_patch(r.l4c, h.src, r.nsrc);
			if (is_udp && r.l4c == CSUM_ZERO)
				r.l4c = CSUM_ONES;
			r.l4c = csum_patch(r.l4c, h.dst, r.ndst);
			if (is_udp && r.l4c == CSUM_ZERO)
				r.l4c = CSUM_ONES;
		end
		return r;
	endfunction

	// Sender: offer the oldest pending item unless idling
	always @(negedge clk) begin
		if (header_pending.size() != 0 && (quiet || $urandom_range(99) >= 29)) begin
			push    <= 1'b1;
			cur_hdr <= header_pending[0];
		end else begin
			push <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			rewrite_expected.push_back(predict_rewrite(cur_hdr, mask_shadow));
			void'(header_pending.pop_front());
		end
	end

	// Receiver: one long hold-off on request, random gaps otherwise unless quiet
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			pop       <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop       <= 1'b0;
		end else begin
			pop <= quiet || ($urandom_range(99) >= 29);
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && pop && !empty) begin
			if (rewrite_expected.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("ERROR: result with nothing expected: src=%h dst=%h ipc=%h l4c=%h chg=%b",
						new_src_addr, new_dst_addr, new_ip_checksum, new_l4_checksum,
						l4_changed);
			end else begin
				want = rewrite_expected.pop_front();
				if (new_src_addr !== want.nsrc || new_dst_addr !== want.ndst
					|| new_ip_checksum !== want.ipc || new_l4_checksum !== want.l4c
					|| l4_changed !== want.changed) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("ERROR: mismatch at %0t", $realtime);
						$display("  exp src=%h dst=%h ipc=%h l4c=%h chg=%b",
							want.nsrc, want.ndst, want.ipc, want.l4c, want.changed);
						$display("  got src=%h dst=%h ipc=%h l4c=%h chg=%b",
							new_src_addr, new_dst_addr, new_ip_checksum, new_l4_checksum,
							l4_changed);
					end
				end
			end
		end
	end

	task automatic add_hdr(input logic [7:0] proto, input logic [31:0] src,
		input logic [31:0] dst, input logic [15:0] ipc, input logic [15:0] l4c);
		header_t h;
		h.proto = proto;
		h.src   = src;
		h.dst   = dst;
		h.ipc   = ipc;
		h.l4c   = l4c;
		header_pending.push_back(h);
	endtask

	function automatic logic [31:0] rand_addr();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return 32'h0000_0000;
		if (r < 10)
			return 32'hffff_ffff;
		return $urandom;
	endfunction

	function automatic logic [15:0] rand_csum();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return CSUM_ZERO;
		if (r < 10)
			return CSUM_ONES;
		return 16'($urandom_range(65535));
	endfunction

	// Mostly TCP and UDP so the checksum repair path is exercised
	task automatic queue_random(input int unsigned n);
		int unsigned r;
		logic [7:0]  proto;
		logic [15:0] l4c;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 35)
				proto = PROTO_TCP;
			else if (r < 70)
				proto = PROTO_UDP;
			else
				proto = 8'($urandom_range(255));
			l4c = rand_csum();
			if (proto == PROTO_UDP && $urandom_range(9) == 0)
				l4c = CSUM_ZERO;
			add_hdr(proto, rand_addr(), rand_addr(), rand_csum(), l4c);
		end
	endtask

	task automatic write_mask(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mask_shadow = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every item is sent and answered, then let the pipeline settle
	task automatic drain();
		while (header_pending.size() != 0 || rewrite_expected.size() != 0 || push)
			@(posedge clk);
		repeat (COOLDOWN) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Reset mask: no address change, only the 0xffff-versus-0 forms move
		add_hdr(PROTO_TCP, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000);
		add_hdr(PROTO_TCP, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
		add_hdr(PROTO_UDP, 32'h0a00_0001, 32'hc0a8_0101, 16'h1c46, 16'h0000);
		add_hdr(PROTO_UDP, 32'h0a00_0001, 32'hc0a8_0101, 16'h1c46, 16'hffff);
		add_hdr(PROTO_UDP, 32'h7f00_0001, 32'h0808_0808, 16'hb1e6, 16'h1234);
		add_hdr(8'd0, 32'h1234_5678, 32'h9abc_def0, 16'h5555, 16'haaaa);
		add_hdr(8'd255, 32'hdead_beef, 32'hcafe_f00d, 16'h0001, 16'hfffe);
		drain();

		write_mask(32'hffff_ffff);
		add_hdr(PROTO_TCP, 32'h0000_0000, 32'hffff_ffff, 16'h0000, 16'h0000);
		add_hdr(PROTO_TCP, 32'hffff_ffff, 32'h0000_0000, 16'hffff, 16'hffff);
		add_hdr(PROTO_UDP, 32'h0000_0000, 32'hffff_ffff, 16'h0000, 16'h0000);
		add_hdr(PROTO_UDP, 32'h0000_0000, 32'hffff_ffff, 16'hffff, 16'hffff);
		add_hdr(PROTO_UDP, 32'h0000_0000, 32'hffff_ffff, 16'h8000, 16'h0001);
		add_hdr(PROTO_UDP, 32'hffff_ffff, 32'h0000_0000, 16'h0000, 16'hffff);
		add_hdr(8'd5, 32'h0102_0304, 32'h0506_0708, 16'h1111, 16'h2222);
		add_hdr(8'd7, 32'h0102_0304, 32'h0506_0708, 16'h1111, 16'h2222);
		add_hdr(8'd16, 32'h0102_0304, 32'h0506_0708, 16'h1111, 16'h2222);
		add_hdr(8'd18, 32'h0102_0304, 32'h0506_0708, 16'h1111, 16'h0000);
		drain();

		write_mask(32'h00ff_0f0f);
		add_hdr(PROTO_TCP, 32'hc0a8_0001, 32'h0aff_ffff, 16'h7a3c, 16'h4d2e);
		add_hdr(PROTO_UDP, 32'hc0a8_0001, 32'h0aff_ffff, 16'h7a3c, 16'h4d2e);
		add_hdr(PROTO_UDP, 32'h00ff_0f0f, 32'hff00_f0f0, 16'h7a3c, 16'hffff);
		add_hdr(8'd1, 32'hc0a8_0001, 32'h0aff_ffff, 16'h7a3c, 16'h4d2e);
		drain();

		write_mask($urandom);
		queue_random(110);
		drain();

		// Back-to-back traffic while the receiver holds off: the unit must fill up
		write_mask(32'h0000_0000);
		quiet   = 1'b1;
		hold_go = 1'b1;
		queue_random(110);
		drain();
		quiet = 1'b0;

		write_mask($urandom & $urandom);
		queue_random(110);
		drain();

		write_mask(32'hffff_ffff);
		queue_random(110);
		drain();

		if (rewrite_expected.size() != 0)
			err_cnt++;
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
